### rtl/tes_pkg.sv
// Package for the task execution statistics table.
// Holds payload structs, table entry layout and controller/datapath link types.
// No dependencies.
package tes_pkg;

  localparam int unsigned TableEntriesDef = 16;

  localparam int unsigned IdW    = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned TotalW = 48;
  localparam int unsigned RunsW  = 32;
  localparam int unsigned MeanW  = 32;

  typedef struct packed {
    logic [IdW-1:0]   task_id;
    logic [TimeW-1:0] exec_time;
  } in_t;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic              created;
    logic              table_full;
    logic [TotalW-1:0] total_time;
    logic [RunsW-1:0]  run_count;
    logic [TimeW-1:0]  longest_time;
    logic [MeanW-1:0]  mean_time;
  } out_t;

  // One row of the statistics table
  typedef struct packed {
    logic [IdW-1:0]    task_id;
    logic [TotalW-1:0] total;
    logic [RunsW-1:0]  runs;
    logic [TimeW-1:0]  longest;
  } entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic inc_idx;
    logic upd_hit;
    logic upd_new;
    logic set_full;
    logic div_start;
    logic load_out;
  } tes_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic enabled;
    logic used_zero;
    logic idx_last;
    logic match;
    logic room;
    logic div_busy;
    logic out_free;
  } tes_sts_t;

endpackage

### rtl/tes_div.sv
// Radix-2 restoring divider: 48-bit dividend by 32-bit divisor, one bit per cycle.
// Quotient saturates to 32 bits; a zero divisor gives zero. Uses tes_pkg.
module tes_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tes_pkg::TotalW-1:0] dividend_i,
  input  logic [tes_pkg::RunsW-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [tes_pkg::MeanW-1:0]  quot_o
);
  import tes_pkg::*;

  localparam int unsigned CntW = $clog2(TotalW);

  logic [TotalW-1:0] dvd_q, dvd_d;
  logic [RunsW-1:0]  rem_q, rem_d;
  logic [RunsW-1:0]  dvs_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              zero_q;
  logic [RunsW:0]    shifted;
  logic [RunsW:0]    diff;
  logic              ge;

  assign shifted = {rem_q, dvd_q[TotalW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(TotalW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[TotalW-2:0], ge};
      rem_d = ge ? diff[RunsW-1:0] : shifted[RunsW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    if (start_i) begin
      dvs_q  <= divisor_i;
      zero_q <= (divisor_i == '0);
    end
  end

  always_comb begin
    if (zero_q) begin
      quot_o = '0;
    end else if (|dvd_q[TotalW-1:MeanW]) begin
      quot_o = '1;
    end else begin
      quot_o = dvd_q[MeanW-1:0];
    end
  end

  assign busy_o = busy_q;

endmodule

### rtl/tes_datapath.sv
// Datapath: enable register, entry memory, search index, update arithmetic,
// divider and output register. Uses tes_pkg and tes_div.
module tes_datapath #(
  parameter int unsigned TABLE_ENTRIES = tes_pkg::TableEntriesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  tes_pkg::in_t      in_data_i,
  input  tes_pkg::tes_cmd_t cmd_i,
  output tes_pkg::tes_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tes_pkg::out_t     out_data_o
);
  import tes_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  entry_t            tbl_mem [TABLE_ENTRIES];
  entry_t            rd_q;
  logic              en_q;
  logic [CntW-1:0]   used_q;
  logic [IdxW-1:0]   idx_q;
  logic [IdW-1:0]    id_q;
  logic [TimeW-1:0]  t_q;
  logic              created_q;
  logic              full_q;
  logic [TotalW-1:0] res_total_q;
  logic [RunsW-1:0]  res_runs_q;
  logic [TimeW-1:0]  res_long_q;
  logic              out_valid_q;
  out_t              out_q;

  logic [TotalW:0]   sum;
  logic [TotalW-1:0] hit_total;
  logic [RunsW-1:0]  hit_runs;
  logic [TimeW-1:0]  hit_long;
  logic [MeanW-1:0]  quot;
  logic              div_busy;
  logic              mem_we;
  logic [IdxW-1:0]   mem_wa;
  entry_t            mem_wd;

  // Saturating update of the matched row
  assign sum       = {1'b0, rd_q.total} + (TotalW + 1)'(t_q);
  assign hit_total = sum[TotalW] ? '1 : sum[TotalW-1:0];
  assign hit_runs  = (rd_q.runs == '1) ? rd_q.runs : rd_q.runs + 1'b1;
  assign hit_long  = (t_q > rd_q.longest) ? t_q : rd_q.longest;

  always_comb begin
    mem_we = cmd_i.upd_hit | cmd_i.upd_new;
    if (cmd_i.upd_hit) begin
      mem_wa = idx_q;
      mem_wd = '{task_id: id_q, total: hit_total, runs: hit_runs, longest: hit_long};
    end else begin
      mem_wa = used_q[IdxW-1:0];
      mem_wd = '{task_id: id_q, total: TotalW'(t_q), runs: RunsW'(1), longest: t_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd_en) begin
      rd_q <= tbl_mem[idx_q];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (cmd_i.upd_new) begin
        used_q <= used_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q      <= in_data_i.task_id;
      t_q       <= in_data_i.exec_time;
      idx_q     <= '0;
      created_q <= 1'b0;
      full_q    <= 1'b0;
    end
    if (cmd_i.inc_idx) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.upd_hit) begin
      res_total_q <= hit_total;
      res_runs_q  <= hit_runs;
      res_long_q  <= hit_long;
    end
    if (cmd_i.upd_new) begin
      idx_q       <= used_q[IdxW-1:0];
      created_q   <= 1'b1;
      res_total_q <= TotalW'(t_q);
      res_runs_q  <= RunsW'(1);
      res_long_q  <= t_q;
    end
    if (cmd_i.set_full) begin
      full_q <= 1'b1;
    end
    if (cmd_i.load_out) begin
      if (full_q) begin
        out_q <= '{slot: '0, created: 1'b0, table_full: 1'b1,
                   total_time: '0, run_count: '0,
                   longest_time: '0, mean_time: '0};
      end else begin
        out_q <= '{slot: SlotW'(idx_q), created: created_q, table_full: 1'b0,
                   total_time: res_total_q, run_count: res_runs_q,
                   longest_time: res_long_q, mean_time: quot};
      end
    end
  end

  tes_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (res_total_q),
    .divisor_i  (res_runs_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign sts_o.enabled   = en_q;
  assign sts_o.used_zero = (used_q == '0);
  assign sts_o.idx_last  = ((CntW'(idx_q) + 1'b1) == used_q);
  assign sts_o.match     = (rd_q.task_id == id_q);
  assign sts_o.room      = (used_q < CntW'(TABLE_ENTRIES));
  assign sts_o.div_busy  = div_busy;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/tes_ctrl.sv
// Controller state machine: accept, linear search, update, divide, hand off.
// Uses tes_pkg command/status structs.
module tes_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tes_pkg::tes_sts_t sts_i,
  output tes_pkg::tes_cmd_t cmd_o
);
  import tes_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StCmp   = 3'd2;
  localparam logic [2:0] StHit   = 3'd3;
  localparam logic [2:0] StMiss  = 3'd4;
  localparam logic [2:0] StStart = 3'd5;
  localparam logic [2:0] StDiv   = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && sts_i.enabled) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.used_zero ? StMiss : StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d = StCmp;
      end
      StCmp: begin
        if (sts_i.match) begin
          state_d = StHit;
        end else if (sts_i.idx_last) begin
          state_d = StMiss;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d = StRead;
        end
      end
      StHit: begin
        cmd_o.upd_hit = 1'b1;
        state_d = StStart;
      end
      StMiss: begin
        if (sts_i.room) begin
          cmd_o.upd_new = 1'b1;
          state_d = StStart;
        end else begin
          cmd_o.set_full = 1'b1;
          state_d = StOut;
        end
      end
      StStart: begin
        cmd_o.div_start = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        if (!sts_i.div_busy) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/task_execution_stats_table.sv
// Task execution statistics table, top level. An input transfer is searched against
// the used entries (a read state and a compare state per entry), the row is updated
// and the 48-step divider forms the mean. A new id on a full table skips the divide.
// One item in flight: the next is taken the cycle after its result loads; disabled
// items are accepted and dropped with no result.
// Reset (async, low) empties the table and clears the enable; entry rows are not cleared.
module task_execution_stats_table #(
  parameter int unsigned TABLE_ENTRIES = tes_pkg::TableEntriesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration: monitor enable
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  // input item channel
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tes_pkg::in_t  in_data_i,
  // result channel
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tes_pkg::out_t out_data_o
);
  import tes_pkg::*;

  tes_cmd_t cmd;
  tes_sts_t sts;

  // Controller sequences the search over the used entries, the row update
  // (hit, new entry, or table full) and the mean division.
  tes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath owns the table memory, the saturating arithmetic, the divider and
  // the output register, so a waiting result never blocks the next transfer in.
  tes_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### dv/tb_task_execution_stats_table.sv
// Self-checking testbench for task_execution_stats_table.
// Drives task records over valid/ready, predicts every stats result in-bench.
// Depends on rtl/tes_pkg.sv and rtl/task_execution_stats_table.sv.
module tb_task_execution_stats_table;
  timeunit 1ns;
  timeprecision 1ps;

  import tes_pkg::*;

  localparam int unsigned TableEntries = TableEntriesDef;
  // Margin above the worst case for one recorded item plus output stalls; round up
  localparam int unsigned DrainCycles  = 200;
  localparam int unsigned RandomItems  = 1650;
  localparam int unsigned MaxReports   = 10;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  task_execution_stats_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the statistics table and the enable bit
  // ---------------------------------------------------------------------------
  logic [IdW-1:0]    ids_q   [TableEntries];
  logic [TotalW-1:0] tot_q   [TableEntries];
  logic [RunsW-1:0]  runs_q  [TableEntries];
  logic [TimeW-1:0]  peak_q  [TableEntries];
  int unsigned       fill_cnt = 0;
  logic              monitor_on;

  out_t pending_stats[$];   // expected results, oldest first
  int   mismatch_cnt = 0;
  logic steady_run;         // set during the stretch with no idling on either side

  // Linear search over the used part of the table only
  function automatic int find_slot(input logic [IdW-1:0] id);
    for (int k = 0; k < int'(fill_cnt); k++) begin
      if (ids_q[k] == id) return k;
    end
    return -1;
  endfunction

  // Records one run in the shadow table and returns the result it must produce
  function automatic out_t tally_run(input logic [IdW-1:0] id, input logic [TimeW-1:0] t);
    out_t            r;
    int              hit;
    logic [TotalW:0] sum;
    logic [TotalW-1:0] quot;
    r   = '0;
    hit = find_slot(id);
    if (hit < 0 && fill_cnt >= TableEntries) begin
      // new id, no room: dropped, everything but the flag is zero
      r.table_full = 1'b1;
      return r;
    end
    if (hit >= 0) begin
      sum         = {1'b0, tot_q[hit]} + (TotalW+1)'(t);
      tot_q[hit]  = sum[TotalW] ? '1 : sum[TotalW-1:0];
      if (runs_q[hit] != '1) runs_q[hit] = runs_q[hit] + 1'b1;
      if (t > peak_q[hit]) peak_q[hit] = t;
    end else begin
      hit         = int'(fill_cnt);
      ids_q[hit]  = id;
      tot_q[hit]  = TotalW'(t);
      runs_q[hit] = RunsW'(1);
      peak_q[hit] = t;
      fill_cnt    = fill_cnt + 1;
      r.created   = 1'b1;
    end
    quot           = tot_q[hit] / TotalW'(runs_q[hit]);
    r.slot         = hit[SlotW-1:0];
    r.total_time   = tot_q[hit];
    r.run_count    = runs_q[hit];
    r.longest_time = peak_q[hit];
    r.mean_time    = (quot > TotalW'({MeanW{1'b1}})) ? '1 : quot[MeanW-1:0];
    return r;
  endfunction

  // Random id not yet in the table
  function automatic logic [IdW-1:0] fresh_id();
    logic [IdW-1:0] id;
    do id = $urandom; while (find_slot(id) >= 0);
    return id;
  endfunction

  // Times lean toward the edges: zero, all ones, small values, top bit set
  function automatic logic [TimeW-1:0] pick_time();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return TimeW'($urandom_range(1000));
      4:       return {1'b1, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic string fmt_stats(input out_t s);
    return $sformatf("slot=%0d new=%0b full=%0b total=%h runs=%h peak=%h mean=%h",
                     s.slot, s.created, s.table_full, s.total_time, s.run_count,
                     s.longest_time, s.mean_time);
  endfunction

  function automatic void note_failure(input string msg);
    if (mismatch_cnt < MaxReports) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, and receiver back-pressure
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Ready toggles on the falling edge; held high through the steady stretch
  always @(negedge clk_i) begin
    out_ready_i <= steady_run || ($urandom_range(99) >= 21);
  end

  // Input monitor: every accepted transfer while enabled yields one expectation.
  // Sampled at the rising edge, so the values seen are the ones the DUT sees.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o && monitor_on) begin
      pending_stats = {pending_stats, tally_run(in_data_i.task_id, in_data_i.exec_time)};
    end
  end

  // Result checker: compare each accepted transfer with the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_stats.size() == 0) begin
        note_failure({"unexpected result: ", fmt_stats(out_data_o)});
      end else begin
        want = pending_stats.pop_front();
        if (out_data_o.slot         !== want.slot         ||
            out_data_o.created      !== want.created      ||
            out_data_o.table_full   !== want.table_full   ||
            out_data_o.total_time   !== want.total_time   ||
            out_data_o.run_count    !== want.run_count    ||
            out_data_o.longest_time !== want.longest_time ||
            out_data_o.mean_time    !== want.mean_time) begin
          note_failure({"mismatch\n  exp: ", fmt_stats(want),
                        "\n  act: ", fmt_stats(out_data_o)});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driver tasks
  // ---------------------------------------------------------------------------

  // One task record. Valid stays high into the next call unless a gap is taken,
  // so a back-to-back item never sees valid dropped and raised in one step.
  task automatic send_item(input logic [IdW-1:0] id, input logic [TimeW-1:0] t);
    int unsigned gap;
    gap = (!steady_run && $urandom_range(99) < 21) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= '{task_id: id, exec_time: t};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and let every expected result drain, plus the latency margin so
  // an ignored item still in the pipe is gone before the next register write
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_monitor(input logic on);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    monitor_on  = on;   // DUT takes it at the coming rising edge; nothing in flight
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Enable is off out of reset: records must vanish without a result
  task automatic test_ignored_after_reset();
    send_item('0, '0);
    send_item('1, '1);
    for (int i = 0; i < 6; i++) send_item($urandom, pick_time());
  endtask

  // Build the table from empty to full, then hit it and overflow it
  task automatic test_table_build();
    set_monitor(1'b1);
    send_item('0, '0);                    // new entry, mean of zero time
    send_item('1, '1);                    // extreme id and time
    send_item('0, '1);                    // hit raises the longest time
    send_item('0, 32'd1);                 // mean truncates: (2^32) / 3
    send_item('1, '0);                    // longest and total stay, run count grows
    send_item(32'hAAAA_AAAA, 32'd7);
    send_item(32'h5555_5555, 32'h8000_0000);
    send_item(32'h8000_0000, 32'd1);
    send_item(32'h0000_0001, 32'd5);
    // fill the remaining slots with fresh ids
    while (fill_cnt < TableEntries) send_item(fresh_id(), pick_time());
    // table full: new ids are flagged and dropped
    send_item(fresh_id(), pick_time());
    send_item(32'hFFFF_FFFE, '0);
    // last slot still reachable
    send_item(ids_q[TableEntries-1], '1);
  endtask

  // Disabled traffic must leave the table untouched; writing the same value
  // twice covers a redundant register write
  task automatic test_off_keeps_state();
    set_monitor(1'b0);
    for (int i = 0; i < 10; i++) send_item(ids_q[$urandom_range(TableEntries-1)], '1);
    for (int i = 0; i < 10; i++) send_item(fresh_id(), pick_time());
    set_monitor(1'b0);
    set_monitor(1'b1);
    // state check: the first four entries answer with their pre-disable totals plus one run
    for (int i = 0; i < 4; i++) send_item(ids_q[i], pick_time());
  endtask

  // Mostly hits on live entries with random times; fresh and near-miss ids
  // probe the full-table path. One disabled window in the middle.
  task automatic test_random_traffic();
    logic [IdW-1:0] id;
    int unsigned    pick;
    for (int i = 0; i < int'(RandomItems); i++) begin
      steady_run = (i >= 500 && i < 800);
      if (i == 1100) begin
        set_monitor(1'b0);
        for (int j = 0; j < 40; j++) send_item($urandom, pick_time());
        set_monitor(1'b1);
      end
      pick = $urandom_range(99);
      if (pick < 78)      id = ids_q[$urandom_range(fill_cnt - 1)];
      else if (pick < 92) id = fresh_id();
      else                id = ids_q[$urandom_range(fill_cnt - 1)] ^ (32'd1 << $urandom_range(31));
      send_item(id, pick_time());
    end
    steady_run = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    steady_run   = 1'b0;
    monitor_on   = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_ignored_after_reset();
    test_table_build();
    test_off_keeps_state();
    test_random_traffic();

    settle();
    if (mismatch_cnt == 0) begin
      $display("tb_task_execution_stats_table: PASS");
    end else begin
      $display("tb_task_execution_stats_table: FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run
  initial begin
    #40ms;
    $display("tb_task_execution_stats_table: FAIL");
    $finish;
  end

endmodule
